[rtl/jse_pkg.sv]
// Shared types, constants and helper functions of the JSON string escaper.
`default_nettype none

package jse_pkg;

    // Field widths
    localparam int BYTE_W = 8;
    localparam int CAP_W  = 16;
    localparam int LEN_W  = 3;

    // Defaults
    localparam logic [CAP_W-1:0] CAP_RESET         = 16'd256;
    localparam int               QUEUE_DEPTH_DEF   = 4;

    // Escape constants
    localparam logic [BYTE_W-1:0] CTRL_LIMIT = 8'h20;
    localparam logic [LEN_W-1:0]  UNI_LEN    = 3'd6;
    localparam logic [LEN_W-1:0]  SHORT_LEN  = 3'd2;
    localparam logic [LEN_W-1:0]  ONE_LEN    = 3'd1;

    // Character codes
    localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;
    localparam logic [BYTE_W-1:0] CH_BS     = 8'h08;
    localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
    localparam logic [BYTE_W-1:0] CH_LF     = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_CR     = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
    localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_HEXA_M10 = 8'h57; // 'a' minus ten
    localparam logic [BYTE_W-1:0] CH_LOW_B  = 8'h62;
    localparam logic [BYTE_W-1:0] CH_LOW_N  = 8'h6E;
    localparam logic [BYTE_W-1:0] CH_LOW_R  = 8'h72;
    localparam logic [BYTE_W-1:0] CH_LOW_T  = 8'h74;
    localparam logic [BYTE_W-1:0] CH_LOW_U  = 8'h75;

    // Kind of work handed from front to back
    typedef enum logic [1:0] {
        KIND_PLAIN,
        KIND_SHORT,
        KIND_UNI,
        KIND_TERM
    } t_kind;

    // One queued descriptor: kind plus the byte it needs
    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] data;
    } t_desc;

    // Letter of a two-byte escape, zero when the byte has none
    function automatic logic [BYTE_W-1:0] short_letter(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] l;
        unique case (b)
            CH_QUOTE:  l = CH_QUOTE;
            CH_BSLASH: l = CH_BSLASH;
            CH_BS:     l = CH_LOW_B;
            CH_LF:     l = CH_LOW_N;
            CH_CR:     l = CH_LOW_R;
            CH_TAB:    l = CH_LOW_T;
            default:   l = CH_NUL;
        endcase
        return l;
    endfunction

    // Number of bytes a descriptor expands into
    function automatic logic [LEN_W-1:0] kind_len(input t_kind k);
        logic [LEN_W-1:0] n;
        unique case (k)
            KIND_SHORT: n = SHORT_LEN;
            KIND_UNI:   n = UNI_LEN;
            default:    n = ONE_LEN;
        endcase
        return n;
    endfunction

    // Lowercase hex digit
    function automatic logic [BYTE_W-1:0] hex_digit(input logic [3:0] n);
        logic [BYTE_W-1:0] d;
        if (n < 4'd10) begin
            d = CH_ZERO + {4'b0, n};
        end else begin
            d = CH_HEXA_M10 + {4'b0, n};
        end
        return d;
    endfunction

endpackage

`default_nettype wire

[rtl/jse_front.sv]
// Front end: classifies input bytes, tracks the output budget and queues work.
`default_nettype none

module jse_front
    import jse_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [CAP_W-1:0]  i_cfg_wdata,
    input  wire logic              i_accept,
    input  wire logic [BYTE_W-1:0] i_byte,
    output logic                   o_push,
    output t_desc                  o_desc
);

    logic [CAP_W-1:0] r_capacity;
    logic [CAP_W-1:0] r_budget;
    logic [CAP_W-1:0] n_budget;
    logic             r_halted;
    logic             n_halted;
    logic [CAP_W-1:0] reload;
    logic [BYTE_W-1:0] letter;
    t_kind            kind;
    logic [LEN_W-1:0] len;

    // Capacity register; zero behaves as one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (i_cfg_we) begin
            r_capacity <= i_cfg_wdata;
        end
    end

    assign reload = (r_capacity == '0) ? '0 : r_capacity - CAP_W'(1);

    // Classify the incoming byte
    always_comb begin
        letter = short_letter(i_byte);
        if (i_byte == CH_NUL) begin
            kind = KIND_TERM;
        end else if (letter != CH_NUL) begin
            kind = KIND_SHORT;
        end else if (i_byte < CTRL_LIMIT) begin
            kind = KIND_UNI;
        end else begin
            kind = KIND_PLAIN;
        end
        len = kind_len(kind);
    end

    // Budget check and descriptor build
    always_comb begin
        n_budget    = r_budget;
        n_halted    = r_halted;
        o_push      = 1'b0;
        o_desc.kind = kind;
        o_desc.data = (kind == KIND_SHORT) ? letter : i_byte;
        if (i_accept) begin
            if (kind == KIND_TERM) begin
                o_push   = 1'b1;
                n_budget = reload;
                n_halted = 1'b0;
            end else if (!r_halted) begin
                if (r_budget < {{(CAP_W-LEN_W){1'b0}}, len}) begin
                    n_halted = 1'b1;
                end else begin
                    o_push   = 1'b1;
                    n_budget = r_budget - {{(CAP_W-LEN_W){1'b0}}, len};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_budget <= CAP_RESET - CAP_W'(1);
            r_halted <= 1'b0;
        end else begin
            r_budget <= n_budget;
            r_halted <= n_halted;
        end
    end

endmodule

`default_nettype wire

[rtl/jse_queue.sv]
// Descriptor queue between the front end and the expander.
`default_nettype none

module jse_queue
    import jse_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_desc i_desc,
    input  wire logic  i_pop,
    output logic       o_full,
    output logic       o_valid,
    output t_desc      o_desc
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_desc            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push_ok;
    logic             pop_ok;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_desc  = r_mem[r_rd_ptr];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && o_valid;

    // Storage
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_desc;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (pop_ok) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (push_ok && !pop_ok) begin
                r_count <= r_count + CNT_W'(1);
            end else if (pop_ok && !push_ok) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count above depth");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("pop from empty queue");
    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push_ok && !pop_ok) |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("queue count did not advance");
`endif

endmodule

`default_nettype wire

[rtl/jse_back.sv]
// Expander: turns descriptors into registered output bytes, one per cycle unless stalled.
`default_nettype none

module jse_back
    import jse_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_q_valid,
    input  wire t_desc             i_q_desc,
    output logic                   o_pop,
    output logic                   o_valid,
    output logic [BYTE_W-1:0]      o_data,
    output logic                   o_last,
    output logic                   o_end,
    input  wire logic              i_ready
);

    logic [LEN_W-1:0]  r_idx;
    logic              r_valid;
    logic [BYTE_W-1:0] r_data;
    logic              r_last;
    logic              r_end;
    logic              advance;
    logic              step;
    logic              last_byte;
    logic [BYTE_W-1:0] cur_byte;

    assign advance   = !r_valid || i_ready;
    assign step      = advance && i_q_valid;
    assign last_byte = (r_idx == kind_len(i_q_desc.kind) - LEN_W'(1));
    assign o_pop     = step && last_byte;

    // Select the byte at the current position of the escape sequence
    always_comb begin
        unique case (i_q_desc.kind)
            KIND_PLAIN: cur_byte = i_q_desc.data;
            KIND_TERM:  cur_byte = CH_NUL;
            KIND_SHORT: cur_byte = (r_idx == '0) ? CH_BSLASH : i_q_desc.data;
            KIND_UNI: begin
                unique case (r_idx)
                    3'd0:    cur_byte = CH_BSLASH;
                    3'd1:    cur_byte = CH_LOW_U;
                    3'd2:    cur_byte = CH_ZERO;
                    3'd3:    cur_byte = CH_ZERO;
                    3'd4:    cur_byte = hex_digit(i_q_desc.data[7:4]);
                    default: cur_byte = hex_digit(i_q_desc.data[3:0]);
                endcase
            end
            default:    cur_byte = CH_NUL;
        endcase
    end

    // Position counter within the current descriptor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (step) begin
            r_idx <= last_byte ? '0 : r_idx + LEN_W'(1);
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (advance) begin
            r_valid <= i_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_data <= cur_byte;
            r_last <= last_byte;
            r_end  <= (i_q_desc.kind == KIND_TERM);
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_last  = r_last;
    assign o_end   = r_end;

`ifndef SYNTH
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx != '0) |-> (i_q_valid && (i_q_desc.kind == KIND_SHORT
                                         || i_q_desc.kind == KIND_UNI)))
        else $error("position counter set outside a multi-byte escape");
    a_end_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_end) |-> (r_last && r_data == CH_NUL))
        else $error("terminator word malformed");
`endif

endmodule

`default_nettype wire

[rtl/json_string_escaper_top.sv]
// Top level of the JSON string escaper: front end, descriptor queue and expander.
`default_nettype none

// One string byte per input word; each accepted byte yields zero to six output
// words. Plain bytes and terminators become one word each, a two-letter escape
// two words and a \u00xx escape six, as the expander emits exactly one byte per
// cycle unless the output stalls. Input words are taken every cycle while the
// descriptor queue (QUEUE_DEPTH entries) has room; bytes dropped after the
// budget ran out are taken at one per cycle and emit nothing. Each byte is
// registered in the queue, then in the output register. A new buffer_capacity
// takes effect at the next terminator; write it only while the block is idle.
module json_string_escaper_top
    import jse_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [CAP_W-1:0] i_cfg_wdata,   // buffer_capacity
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire logic [7:0]       s_axis_tdata,  // [7:0] char_byte
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    output logic [7:0]            m_axis_tdata,  // [7:0] out_byte
    output logic                  m_axis_tlast,  // run_last
    output logic                  m_axis_tuser   // [0] string_end
);

    logic  q_full;
    logic  q_valid;
    logic  push;
    logic  pop;
    logic  in_accept;
    t_desc push_desc;
    t_desc head_desc;

    assign s_axis_tready = !q_full;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    jse_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (in_accept),
        .i_byte      (s_axis_tdata),
        .o_push      (push),
        .o_desc      (push_desc)
    );

    jse_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_desc  (push_desc),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_desc  (head_desc)
    );

    jse_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_desc  (head_desc),
        .o_pop     (pop),
        .o_valid   (m_axis_tvalid),
        .o_data    (m_axis_tdata),
        .o_last    (m_axis_tlast),
        .o_end     (m_axis_tuser),
        .i_ready   (m_axis_tready)
    );

endmodule

`default_nettype wire
